### design/stepper_pulse_generator_with_endstop_macros.svh
`ifndef STEPPER_PULSE_GENERATOR_WITH_ENDSTOP_MACROS_SVH
`define STEPPER_PULSE_GENERATOR_WITH_ENDSTOP_MACROS_SVH

// same-cycle implication, sampled on clk, quiet while arst_n is low
`define SPGE_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("spge check failed");

// next-cycle implication, sampled on clk, quiet while arst_n is low
`define SPGE_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("spge check failed");

`endif

### design/spge_pkg.sv
`default_nettype none

package spge_pkg;

	localparam int TIME_BITS_DEF = 32;
	localparam int CLK_W         = 31;
	localparam int DEB_W         = 4;
	localparam int STEP_W        = 31;
	localparam int CNT_W         = 32;
	localparam int HP_W          = 32;
	localparam int SCALE_W       = 7;
	localparam int PROD_W        = CLK_W + SCALE_W;
	localparam int ADDR_W        = 4;
	localparam int DATA_W        = 32;

	localparam logic [SCALE_W-1:0] SPEED_SCALE    = 7'd100;
	localparam logic [CLK_W-1:0]   CLOCK_HZ_RST   = 31'd168000000;
	localparam logic               ENDSTOP_DIR_RST = 1'b1;
	localparam logic [DEB_W-1:0]   DEBOUNCE_RST   = 4'd5;
	localparam logic [STEP_W-1:0]  MAX_STEPS      = {STEP_W{1'b1}};
	localparam logic [HP_W-1:0]    HP_MAX         = {HP_W{1'b1}};

	localparam logic KIND_TICK  = 1'b0;
	localparam logic KIND_START = 1'b1;

	typedef enum logic [1:0] {
		REG_CLOCK_HZ    = 2'd0,
		REG_ENDSTOP_DIR = 2'd1,
		REG_DEBOUNCE    = 2'd2
	} reg_idx_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_MUL,
		ST_SAT
	} state_t;

	typedef struct packed {
		logic [CLK_W-1:0] clock_hz;
		logic             endstop_dir;
		logic [DEB_W-1:0] debounce_count;
	} cfg_t;

	typedef struct packed {
		logic tick_en;
		logic start_en;
		logic hp_load;
	} mot_ctrl_t;

endpackage

`default_nettype wire

### design/spge_cfg.sv
`default_nettype none

module spge_cfg
	import spge_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [ADDR_W-1:0] paddr,
	input  wire logic [DATA_W-1:0] pwdata,
	output logic      [DATA_W-1:0] prdata,
	output logic                   pready,
	output cfg_t                   cfg
);

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr_en;

	assign idx    = reg_idx_t'(paddr[3:2]);
	assign wr_en  = psel & penable & pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.clock_hz       <= CLOCK_HZ_RST;
			cfg_q.endstop_dir    <= ENDSTOP_DIR_RST;
			cfg_q.debounce_count <= DEBOUNCE_RST;
		end else if (wr_en) begin
			unique case (idx)
				REG_CLOCK_HZ:    cfg_q.clock_hz       <= pwdata[CLK_W-1:0];
				REG_ENDSTOP_DIR: cfg_q.endstop_dir    <= pwdata[0];
				REG_DEBOUNCE:    cfg_q.debounce_count <= pwdata[DEB_W-1:0];
				default:         ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (idx)
			REG_CLOCK_HZ:    prdata = DATA_W'(cfg_q.clock_hz);
			REG_ENDSTOP_DIR: prdata = DATA_W'(cfg_q.endstop_dir);
			REG_DEBOUNCE:    prdata = DATA_W'(cfg_q.debounce_count);
			default:         prdata = '0;
		endcase
	end

endmodule

`default_nettype wire

### design/spge_div.sv
`default_nettype none

module spge_div
	import spge_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire logic [CLK_W-1:0] dividend,
	input  wire logic [CLK_W-1:0] divisor,
	output logic                  done,
	output logic      [CLK_W-1:0] quotient
);

	localparam int ITER_W = $clog2(CLK_W + 1);

	logic [CLK_W-1:0]  dvd_q;
	logic [CLK_W-1:0]  dvs_q;
	logic [CLK_W-1:0]  rem_q;
	logic [ITER_W-1:0] cnt_q;
	logic              busy_q;
	logic              done_q;
	logic [CLK_W:0]    diff;
	logic              qbit;

	// restoring step, one quotient bit a cycle; a zero divisor gives all ones
	assign diff = {rem_q, dvd_q[CLK_W-1]} - {1'b0, dvs_q};
	assign qbit = ({rem_q, dvd_q[CLK_W-1]} >= {1'b0, dvs_q});

	assign done     = done_q;
	assign quotient = dvd_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= ITER_W'(CLK_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == ITER_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dvs_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[CLK_W-2:0], qbit};
			rem_q <= qbit ? diff[CLK_W-1:0] : {rem_q[CLK_W-2:0], dvd_q[CLK_W-1]};
		end
	end

endmodule

`default_nettype wire

### design/spge_motion.sv
`default_nettype none

module spge_motion
	import spge_pkg::*;
#(
	parameter int TIME_BITS = TIME_BITS_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire mot_ctrl_t            ctrl,
	input  wire cfg_t                 cfg,
	input  wire logic [TIME_BITS-1:0] now,
	input  wire logic                 endstop_level,
	input  wire logic [CNT_W-1:0]     step_count,
	input  wire logic                 go_home,
	input  wire logic [HP_W-1:0]      hp_value,
	output logic                      pulse,
	output logic                      move_dir,
	output logic                      active,
	output logic      [STEP_W-1:0]    remaining
);

	localparam int CMP_W = (TIME_BITS > HP_W) ? TIME_BITS : HP_W;

	logic                 active_q;
	logic                 dir_q;
	logic                 phase_q;
	logic                 pulse_q;
	logic [STEP_W-1:0]    steps_q;
	logic [TIME_BITS-1:0] last_q;
	logic [HP_W-1:0]      hp_q;
	logic [DEB_W-1:0]     deb_q;

	logic [DEB_W-1:0]     deb_dec;
	logic                 fired;
	logic [DEB_W-1:0]     deb_next;
	logic [TIME_BITS-1:0] elapsed;
	logic                 due;
	logic                 keep_going;
	logic [CNT_W-1:0]     mag;
	logic                 start_dir;
	logic [STEP_W-1:0]    start_steps;

	assign pulse     = pulse_q;
	assign move_dir  = dir_q;
	assign active    = active_q;
	assign remaining = steps_q;

	// endstop qualifier, wraps within its width
	assign deb_dec  = deb_q - 1'b1;
	assign fired    = endstop_level && (deb_dec == '0);
	assign deb_next = (endstop_level && !fired) ? deb_dec : cfg.debounce_count;

	assign elapsed    = now - last_q;
	assign due        = CMP_W'(elapsed) > CMP_W'(hp_q);
	assign keep_going = (steps_q != '0) && !(fired && (cfg.endstop_dir == dir_q));

	assign mag = -step_count;

	always_comb begin
		if (go_home) begin
			start_dir   = cfg.endstop_dir;
			start_steps = MAX_STEPS;
		end else if (step_count[CNT_W-1]) begin
			start_dir   = 1'b1;
			start_steps = mag[CNT_W-1] ? MAX_STEPS : mag[STEP_W-1:0];
		end else begin
			start_dir   = 1'b0;
			start_steps = step_count[STEP_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			dir_q    <= 1'b0;
			phase_q  <= 1'b1;
			pulse_q  <= 1'b0;
			steps_q  <= '0;
			last_q   <= '0;
			hp_q     <= '0;
			deb_q    <= DEBOUNCE_RST;
		end else if (ctrl.start_en) begin
			active_q <= (start_steps != '0);
			dir_q    <= start_dir;
			phase_q  <= 1'b1;
			steps_q  <= start_steps;
			last_q   <= now;
			deb_q    <= cfg.debounce_count;
		end else if (ctrl.hp_load) begin
			hp_q <= hp_value;
		end else if (ctrl.tick_en && active_q) begin
			deb_q <= deb_next;
			if (!keep_going) begin
				active_q <= 1'b0;
			end else if (due) begin
				last_q  <= last_q + TIME_BITS'(hp_q);
				phase_q <= ~phase_q;
				pulse_q <= ~pulse_q;
				if (!phase_q) begin
					steps_q <= steps_q - 1'b1;
				end
			end
		end
	end

endmodule

`default_nettype wire

### design/stepper_pulse_generator_with_endstop.sv
`default_nettype none
// a tick transaction gives its result in the cycle after acceptance
// a start transaction gives its result after the restoring divider
// (one quotient bit per cycle over 31 bits) and the ST_MUL and ST_SAT states
// throughput: one tick per cycle while out_ready is high, none during a start
// reset: asynchronous on arst_n low, state and config registers to their defaults

module stepper_pulse_generator_with_endstop
	import spge_pkg::*;
#(
	parameter int TIME_BITS = TIME_BITS_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	// configuration port
	input  wire logic                 psel,
	input  wire logic                 penable,
	input  wire logic                 pwrite,
	input  wire logic [ADDR_W-1:0]    paddr,
	input  wire logic [DATA_W-1:0]    pwdata,
	output logic      [DATA_W-1:0]    prdata,
	output logic                      pready,
	// input items
	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  wire logic                 kind,
	input  wire logic [TIME_BITS-1:0] now,
	input  wire logic                 endstop_level,
	input  wire logic [CNT_W-1:0]     step_count,
	input  wire logic                 go_home,
	input  wire logic [CLK_W-1:0]     speed_x100,
	// result items
	output logic                      out_valid,
	input  wire logic                 out_ready,
	output logic                      pulse_level,
	output logic                      dir_level,
	output logic                      busy_res,
	output logic      [STEP_W-1:0]    steps_left
);

	cfg_t              cfg;
	mot_ctrl_t         ctrl;
	state_t            state_q;
	state_t            state_nxt;
	logic              in_acc;
	logic              out_set;
	logic              out_valid_q;
	logic              div_start;
	logic              div_done;
	logic [CLK_W-1:0]  quotient;
	logic [PROD_W-1:0] prod_q;
	logic [HP_W-1:0]   hp_sat;
	logic              move_dir;

	spge_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// the divider: clock_hz / speed_x100
	spge_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (cfg.clock_hz),
		.divisor  (speed_x100),
		.done     (div_done),
		.quotient (quotient)
	);

	spge_motion #(
		.TIME_BITS (TIME_BITS)
	) u_motion (
		.clk           (clk),
		.arst_n        (arst_n),
		.ctrl          (ctrl),
		.cfg           (cfg),
		.now           (now),
		.endstop_level (endstop_level),
		.step_count    (step_count),
		.go_home       (go_home),
		.hp_value      (hp_sat),
		.pulse         (pulse_level),
		.move_dir      (move_dir),
		.active        (busy_res),
		.remaining     (steps_left)
	);

	// a new item enters in the idle state when the result slot is free or drains this cycle;
	// the divider latches speed_x100 at the start, and ready stays low until idle again
	assign in_ready = (state_q == ST_IDLE) && (!out_valid_q || out_ready);
	assign in_acc   = in_valid && in_ready;

	assign out_valid = out_valid_q;
	assign dir_level = ~move_dir;

	// half period scaled by 100, saturating at the top of 32 bits
	assign hp_sat = (prod_q[PROD_W-1:HP_W] != '0) ? HP_MAX : prod_q[HP_W-1:0];

	// next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: if (in_acc && (kind == KIND_START)) state_nxt = ST_DIV;
			ST_DIV:  if (div_done) state_nxt = ST_MUL;
			ST_MUL:  state_nxt = ST_SAT;
			ST_SAT:  state_nxt = ST_IDLE;
			default: state_nxt = ST_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		ctrl      = '0;
		div_start = 1'b0;
		out_set   = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				ctrl.start_en = in_acc && (kind == KIND_START);
				ctrl.tick_en  = in_acc && (kind == KIND_TICK);
				div_start     = in_acc && (kind == KIND_START);
				out_set       = in_acc && (kind == KIND_TICK);
			end
			ST_SAT: begin
				ctrl.hp_load = 1'b1;
				out_set      = 1'b1;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (out_set) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// scale the quotient, registered ahead of the saturation
	always_ff @(posedge clk) begin
		if (state_q == ST_MUL) begin
			prod_q <= PROD_W'(quotient) * PROD_W'(SPEED_SCALE);
		end
	end

endmodule

`default_nettype wire

### design/spge_chk.sv
`default_nettype none
`include "stepper_pulse_generator_with_endstop_macros.svh"

module spge_chk
	import spge_pkg::*;
(
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              in_valid,
	input wire logic              in_ready,
	input wire logic              kind,
	input wire logic              out_valid,
	input wire logic              out_ready,
	input wire logic              pulse_level,
	input wire logic              dir_level,
	input wire logic              busy_res,
	input wire logic [STEP_W-1:0] steps_left
);

	// a waiting result holds
	`SPGE_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(pulse_level) && $stable(dir_level) && $stable(busy_res) && $stable(steps_left))

	// no new transaction while an untaken result blocks the slot
	`SPGE_ASSERT_NOW(a_slot_free, in_ready, !out_valid || out_ready)

	// a tick transaction gives its result in the next cycle
	`SPGE_ASSERT_NEXT(a_tick_result, in_valid && in_ready && (kind == KIND_TICK), out_valid)

	// a start transaction occupies the divider
	`SPGE_ASSERT_NEXT(a_start_busy, in_valid && in_ready && (kind == KIND_START), !in_ready && !out_valid)

endmodule

bind stepper_pulse_generator_with_endstop spge_chk u_spge_chk (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_valid),
	.in_ready    (in_ready),
	.kind        (kind),
	.out_valid   (out_valid),
	.out_ready   (out_ready),
	.pulse_level (pulse_level),
	.dir_level   (dir_level),
	.busy_res    (busy_res),
	.steps_left  (steps_left)
);

`default_nettype wire

### tb/stepper_pulse_generator_with_endstop_tb.sv
`default_nettype none

module stepper_pulse_generator_with_endstop_tb;
	import spge_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	// address that decodes to no register, writes there must be dropped
	localparam logic [ADDR_W-1:0] UNUSED_ADDR = 4'd12;
	// long enough for a start transaction, leave a margin on top
	localparam int DRAIN_CYCLES = 40;

	// one command to the motor block, start or tick
	typedef struct packed {
		logic              kind;
		logic [31:0]       now;
		logic              es;
		logic [CNT_W-1:0]  cnt;
		logic              home;
		logic [CLK_W-1:0]  spd;
	} motor_cmd_t;

	// pin levels reported after one command
	typedef struct packed {
		logic              pulse;
		logic              dir;
		logic              busy;
		logic [STEP_W-1:0] steps;
	} pin_state_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	// apb side
	logic              psel = 1'b0;
	logic              penable = 1'b0;
	logic              pwrite = 1'b0;
	logic [ADDR_W-1:0] paddr = '0;
	logic [DATA_W-1:0] pwdata = '0;
	logic [DATA_W-1:0] prdata;
	logic              pready;

	// command side
	logic              in_valid = 1'b0;
	logic              in_ready;
	logic              kind = KIND_TICK;
	logic [31:0]       now = '0;
	logic              endstop_level = 1'b0;
	logic [CNT_W-1:0]  step_count = '0;
	logic              go_home = 1'b0;
	logic [CLK_W-1:0]  speed_x100 = '0;

	// result side
	logic              out_valid;
	logic              out_ready = 1'b0;
	logic              pulse_level;
	logic              dir_level;
	logic              busy_res;
	logic [STEP_W-1:0] steps_left;

	// commands waiting for the driver, pin states waiting for the monitor
	motor_cmd_t motor_cmds[$];
	pin_state_t pin_states_due[$];
	motor_cmd_t cur_cmd;

	int unsigned cmds_queued = 0;
	int unsigned results_seen = 0;
	int unsigned mismatch_cnt = 0;
	bit          no_stall = 1'b0;

	// register copy as the block should hold it
	cfg_t cfg_mirror = '{clock_hz: CLOCK_HZ_RST, endstop_dir: ENDSTOP_DIR_RST,
		debounce_count: DEBOUNCE_RST};

	// motor state copy, reset values
	logic              m_active = 1'b0;
	logic              m_dir = 1'b0;
	logic              m_phase = 1'b1;
	logic              m_pulse = 1'b0;
	logic [STEP_W-1:0] m_steps = '0;
	logic [31:0]       m_last = '0;
	logic [HP_W-1:0]   m_hp = '0;
	logic [DEB_W-1:0]  m_deb = DEBOUNCE_RST;

	// stimulus-side view of the motion time base
	logic [31:0]       gen_t = '0;
	logic [HP_W-1:0]   gen_hp = '0;

	stepper_pulse_generator_with_endstop u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.kind          (kind),
		.now           (now),
		.endstop_level (endstop_level),
		.step_count    (step_count),
		.go_home       (go_home),
		.speed_x100    (speed_x100),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.pulse_level   (pulse_level),
		.dir_level     (dir_level),
		.busy_res      (busy_res),
		.steps_left    (steps_left)
	);

	always #5 clk = ~clk;

	// half period in ticks: (hz / speed) * 100, saturating, zero speed is the slowest
	function automatic logic [HP_W-1:0] half_period_of(input logic [CLK_W-1:0] hz,
		input logic [CLK_W-1:0] spd);
		logic [63:0] prod;
		if (spd == '0)
			return HP_MAX;
		prod = 64'(hz / spd) * 64'(SPEED_SCALE);
		return (prod > 64'(HP_MAX)) ? HP_MAX : prod[HP_W-1:0];
	endfunction

	// apply one accepted command to the motor copy and queue the pin state it gives
	task automatic advance_motor(input motor_cmd_t c);
		logic [31:0] mag;
		logic [31:0] elapsed;
		logic        fired;
		pin_state_t  ps;
		fired = 1'b0;
		if (c.kind == KIND_START) begin
			if (c.home) begin
				// homing runs toward the endstop with the largest count
				m_dir = cfg_mirror.endstop_dir;
				m_steps = MAX_STEPS;
			end else if (c.cnt[CNT_W-1]) begin
				// backward, magnitude of the most negative count saturates
				mag = -c.cnt;
				m_dir = 1'b1;
				m_steps = (mag > {1'b0, MAX_STEPS}) ? MAX_STEPS : mag[STEP_W-1:0];
			end else begin
				m_dir = 1'b0;
				m_steps = c.cnt[STEP_W-1:0];
			end
			m_hp = half_period_of(cfg_mirror.clock_hz, c.spd);
			m_phase = 1'b1;
			m_last = c.now;
			m_deb = cfg_mirror.debounce_count;
			m_active = (m_steps != '0);
		end else if (m_active) begin
			// endstop qualification, the countdown wraps from zero to fifteen
			if (c.es) begin
				m_deb = m_deb - 1'b1;
				if (m_deb == '0) begin
					fired = 1'b1;
					m_deb = cfg_mirror.debounce_count;
				end
			end else begin
				m_deb = cfg_mirror.debounce_count;
			end
			if (m_steps != '0 && !(fired && cfg_mirror.endstop_dir == m_dir)) begin
				elapsed = c.now - m_last;
				if (elapsed > m_hp) begin
					// advance by exactly one half period, no drift
					m_last = m_last + m_hp;
					if (!m_phase)
						m_steps = m_steps - 1'b1;
					m_phase = ~m_phase;
					m_pulse = ~m_pulse;
				end
			end else begin
				// out of steps or endstop reached, sticky until next start
				m_active = 1'b0;
			end
		end
		ps.pulse = m_pulse;
		ps.dir = ~m_dir;
		ps.busy = m_active;
		ps.steps = m_steps;
		pin_states_due.push_back(ps);
	endtask

	task automatic queue_start(input logic [31:0] t0, input logic [CNT_W-1:0] cnt,
		input logic home, input logic [CLK_W-1:0] spd);
		motor_cmd_t c;
		c.kind = KIND_START;
		c.now = t0;
		c.es = 1'($urandom);
		c.cnt = cnt;
		c.home = home;
		c.spd = spd;
		gen_t = t0;
		gen_hp = half_period_of(cfg_mirror.clock_hz, spd);
		motor_cmds.push_back(c);
		cmds_queued++;
	endtask

	// tick with time advanced by delta, unused fields random
	task automatic queue_tick(input logic [31:0] delta, input logic es);
		motor_cmd_t c;
		gen_t = gen_t + delta;
		c.kind = KIND_TICK;
		c.now = gen_t;
		c.es = es;
		c.cnt = $urandom;
		c.home = 1'($urandom);
		c.spd = 31'($urandom);
		motor_cmds.push_back(c);
		cmds_queued++;
	endtask

	// apb write: setup cycle, access cycle, then release
	task automatic write_reg(input logic [ADDR_W-1:0] addr, input logic [DATA_W-1:0] data);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (addr == {REG_CLOCK_HZ, 2'b00})
			cfg_mirror.clock_hz = data[CLK_W-1:0];
		else if (addr == {REG_ENDSTOP_DIR, 2'b00})
			cfg_mirror.endstop_dir = data[0];
		else if (addr == {REG_DEBOUNCE, 2'b00})
			cfg_mirror.debounce_count = data[DEB_W-1:0];
	endtask

	// upper data bits are random, the block keeps only the register width
	task automatic set_registers(input logic [CLK_W-1:0] hz, input logic dir,
		input logic [DEB_W-1:0] deb);
		logic [DATA_W-1:0] junk;
		junk = $urandom;
		write_reg({REG_CLOCK_HZ, 2'b00}, {junk[31], hz});
		junk = $urandom;
		write_reg({REG_ENDSTOP_DIR, 2'b00}, {junk[31:1], dir});
		junk = $urandom;
		write_reg({REG_DEBOUNCE, 2'b00}, {junk[31:DEB_W], deb});
	endtask

	// every command gives one result, wait until all of them came back
	task automatic wait_drained();
		while (results_seen < cmds_queued)
			@(posedge clk);
	endtask

	// driver: present queued commands, predict on acceptance
	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && in_ready)
				advance_motor(cur_cmd);
			// hold the payload while a transaction waits for ready
			if (!in_valid || in_ready) begin
				if (motor_cmds.size() != 0 && (no_stall || $urandom_range(0, 99) >= 10)) begin
					cur_cmd = motor_cmds.pop_front();
					kind <= cur_cmd.kind;
					now <= cur_cmd.now;
					endstop_level <= cur_cmd.es;
					step_count <= cur_cmd.cnt;
					go_home <= cur_cmd.home;
					speed_x100 <= cur_cmd.spd;
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// monitor: random backpressure, compare each result with the oldest prediction
	always @(posedge clk) begin
		pin_state_t want;
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				results_seen++;
				if (pin_states_due.size() == 0) begin
					mismatch_cnt++;
					if (mismatch_cnt <= 10)
						$display("unexpected result: pulse %0b dir %0b busy %0b steps %0d",
							pulse_level, dir_level, busy_res, steps_left);
				end else begin
					want = pin_states_due.pop_front();
					if (pulse_level !== want.pulse || dir_level !== want.dir ||
						busy_res !== want.busy || steps_left !== want.steps) begin
						mismatch_cnt++;
						if (mismatch_cnt <= 10)
							$display("mismatch: pulse %0b/%0b dir %0b/%0b busy %0b/%0b steps %0d/%0d",
								want.pulse, pulse_level, want.dir, dir_level,
								want.busy, busy_res, want.steps, steps_left);
					end
				end
			end
			out_ready <= no_stall || ($urandom_range(0, 99) >= 10);
		end
	end

	// stimulus and end of run
	initial begin
		int unsigned phase;
		int unsigned r;
		int unsigned sel;
		int unsigned mag;
		int unsigned nticks;
		int unsigned es_start;
		int unsigned es_len;
		int unsigned need;
		int unsigned mode;
		int unsigned phase_end;
		logic [CLK_W-1:0] spd;
		logic [31:0] delta;
		logic es;

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// idle tick with the endstop high changes nothing
		queue_tick(32'd0, 1'b1);
		// two steps at full rate across the time wrap, then the move ends
		queue_start(32'hFFFF_FFFE, 32'd2, 1'b0, 31'h7FFF_FFFF);
		repeat (5) queue_tick(32'd1, 1'b0);
		// most negative count at zero speed, stopped by the endstop
		queue_start($urandom, 32'h8000_0000, 1'b0, 31'd0);
		repeat (5) queue_tick(32'd0, 1'b1);
		// homing with a saturated half period
		queue_start($urandom, $urandom, 1'b1, 31'd1);
		queue_tick(32'd1, 1'b0);
		// endstop fires while moving away from it, motion goes on
		queue_start($urandom, 32'd1, 1'b0, 31'h7FFF_FFFF);
		repeat (5) queue_tick(32'd0, 1'b1);
		repeat (3) queue_tick(32'd1, 1'b0);
		// largest count, then a zero count start that leaves it idle
		queue_start($urandom, 32'h7FFF_FFFF, 1'b0, 31'h7FFF_FFFF);
		queue_start($urandom, 32'd0, 1'b0, 31'd1);

		for (phase = 0; phase < 6; phase++) begin
			wait_drained();
			no_stall = 1'b0;
			case (phase)
				1: set_registers(31'd1, 1'b0, 4'd1);
				2: begin
					set_registers(31'h7FFF_FFFF, 1'b1, 4'd15);
					write_reg(UNUSED_ADDR, $urandom);
				end
				3: set_registers(31'd0, 1'b0, 4'd0);
				4: set_registers(31'($urandom), 1'($urandom), 4'($urandom));
				5: begin
					set_registers(31'd1000, 1'b1, 4'd3);
					// long stretch with no stalls on either side
					no_stall = 1'b1;
				end
				default: ;
			endcase
			phase_end = cmds_queued + 155;
			while (cmds_queued < phase_end) begin
				r = $urandom_range(0, 99);
				sel = $urandom_range(0, 9);
				if (sel == 0)
					spd = '0;
				else if (sel == 1)
					spd = 31'h7FFF_FFFF;
				else if (sel == 2)
					spd = 31'($urandom);
				else if (sel < 6)
					spd = 31'($urandom_range(1, 1000));
				else
					spd = 31'(cfg_mirror.clock_hz / $urandom_range(1, 50));
				need = (cfg_mirror.debounce_count == '0) ? 16 : cfg_mirror.debounce_count;
				if (r < 60) begin
					// ordinary move, sometimes cut short by the next start
					mag = $urandom_range(1, 10);
					queue_start($urandom, ($urandom_range(0, 1) != 0) ? -mag : mag, 1'b0, spd);
					nticks = 2 * mag + $urandom_range(1, 4);
					if ($urandom_range(0, 6) == 0)
						nticks = $urandom_range(0, nticks);
					mode = $urandom_range(0, 2);
					es_start = $urandom_range(0, nticks);
					es_len = $urandom_range(1, need + 2);
				end else if (r < 80) begin
					// homing run that ends on a qualified endstop
					queue_start($urandom, $urandom, 1'b1, spd);
					mode = 2;
					es_start = $urandom_range(0, 10);
					es_len = need + $urandom_range(0, 2);
					nticks = es_start + need + $urandom_range(0, 3);
				end else begin
					// noise: any start, a few random ticks
					queue_start($urandom, $urandom, 1'($urandom), 31'($urandom));
					nticks = $urandom_range(0, 6);
					mode = 1;
					es_start = 0;
					es_len = 0;
				end
				for (int i = 0; i < nticks; i++) begin
					if (mode == 0)
						es = 1'b0;
					else if (mode == 1)
						es = ($urandom_range(0, 2) == 0);
					else
						es = (i >= es_start && i < es_start + es_len);
					sel = $urandom_range(0, 9);
					if (sel == 0)
						delta = '0;
					else if (sel == 1)
						delta = gen_hp;
					else if (sel == 2)
						delta = $urandom;
					else if (sel == 3)
						delta = gen_hp + 32'd2;
					else
						delta = gen_hp + 32'd1;
					queue_tick(delta, es);
				end
			end
		end

		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		// predictions never answered count as failures
		mismatch_cnt += pin_states_due.size();
		if (mismatch_cnt == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

	// watchdog far beyond the slowest correct run
	initial begin
		#5_000_000;
		$display("Regression FAIL");
		$finish;
	end

endmodule

`default_nettype wire

### files.f
+incdir+design
design/spge_pkg.sv
design/spge_cfg.sv
design/spge_div.sv
design/spge_motion.sv
design/stepper_pulse_generator_with_endstop.sv
design/spge_chk.sv
tb/stepper_pulse_generator_with_endstop_tb.sv
